>>> src/egsd_pkg.sv
`default_nettype none

package egsd_pkg;

   // Field widths fixed by the stream format.
   localparam int ByteWidth   = 8;
   localparam int ValueWidth  = 33;
   localparam int SuffixWidth = 32;
   localparam int LenWidth    = 6;
   localparam int StatusWidth = 2;
   localparam int ModeWidth   = 2;
   localparam int CsrWidth    = 6;
   localparam int BitCntWidth = 3;

   // Decode modes.
   localparam logic [ModeWidth-1:0] MODE_UE    = 2'd0;
   localparam logic [ModeWidth-1:0] MODE_SE    = 2'd1;
   localparam logic [ModeWidth-1:0] MODE_FIXED = 2'd2;

   // Result status codes.
   localparam logic [StatusWidth-1:0] ST_OK        = 2'd0;
   localparam logic [StatusWidth-1:0] ST_PREFIX    = 2'd1;
   localparam logic [StatusWidth-1:0] ST_TRUNCATED = 2'd2;

   // Register indexes.
   localparam logic REG_MODE = 1'b0;
   localparam logic REG_FLEN = 1'b1;

   // Fixed length limits and reset value.
   localparam logic [LenWidth-1:0] FLEN_MIN   = 6'd1;
   localparam logic [LenWidth-1:0] FLEN_MAX   = 6'd32;
   localparam logic [LenWidth-1:0] FLEN_RESET = 6'd8;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;
      logic step;
      logic trunc;
      logic drain;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic pend_valid;
      logic out_free;
   } stat_type;

   // One decoded result.
   typedef struct packed {
      logic signed [ValueWidth-1:0] value;
      logic [LenWidth-1:0]          length;
      logic [StatusWidth-1:0]       status;
   } res_type;

endpackage

`default_nettype wire

>>> src/egsd_ctrl.sv
`default_nettype none

module egsd_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_ready,
   input  egsd_pkg::stat_type stat,
   output egsd_pkg::cmd_type  cmd
);
   import egsd_pkg::*;

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_BITS  = 2'd1;
   localparam logic [1:0] S_TRUNC = 2'd2;
   localparam logic [1:0] S_DRAIN = 2'd3;

   logic [1:0]             state_ff, state_in;
   logic [BitCntWidth-1:0] bit_cnt_ff, bit_cnt_in;
   logic                   slot_ok;

   // A step that may make a result needs room in the pending slot.
   assign slot_ok   = !stat.pend_valid || stat.out_free;
   assign req_ready = (state_ff == S_IDLE);

   // Sequencer over the eight bits of a word, then the end checks.
   always_comb begin
      state_in   = state_ff;
      bit_cnt_in = bit_cnt_ff;
      cmd        = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load   = 1'b1;
               bit_cnt_in = '0;
               state_in   = S_BITS;
            end
         end
         S_BITS: begin
            if (slot_ok) begin
               cmd.step   = 1'b1;
               bit_cnt_in = bit_cnt_ff + 1'b1;
               if (bit_cnt_ff == {BitCntWidth{1'b1}}) begin
                  state_in = S_TRUNC;
               end
            end
         end
         S_TRUNC: begin
            if (slot_ok) begin
               cmd.trunc = 1'b1;
               state_in  = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (!stat.pend_valid) begin
               state_in = S_IDLE;
            end else if (stat.out_free) begin
               cmd.drain = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_IDLE;
         bit_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         bit_cnt_ff <= bit_cnt_in;
      end
   end

`ifndef SYNTHESIS
   // At most one command is issued in a cycle.
   assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.trunc, cmd.drain}))
      else $error("more than one datapath command at once");

   // The last result of a word is only moved out when the output slot is free.
   assert property (@(posedge clock) disable iff (reset)
      cmd.drain |-> (stat.pend_valid && stat.out_free))
      else $error("drain without a pending result or a free output");

   // An accepted word always starts with its first bit.
   assert property (@(posedge clock) disable iff (reset)
      cmd.load |=> (state_ff == S_BITS && bit_cnt_ff == '0))
      else $error("word accepted but bit sequence not started");
`endif

endmodule

`default_nettype wire

>>> src/egsd_datapath.sv
`default_nettype none

module egsd_datapath #(
   parameter int MAX_PREFIX = 31
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  egsd_pkg::cmd_type                       cmd,
   output egsd_pkg::stat_type                      stat,
   input  wire  [egsd_pkg::ByteWidth-1:0]          req_stream_byte,
   input  wire                                     req_end_of_stream,
   input  wire                                     csr_write_enable,
   input  wire                                     csr_index,
   input  wire  [egsd_pkg::CsrWidth-1:0]           csr_write_data,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [egsd_pkg::ValueWidth-1:0]  rsp_value,
   output logic [egsd_pkg::LenWidth-1:0]           rsp_code_length,
   output logic [egsd_pkg::StatusWidth-1:0]        rsp_status,
   output logic                                    rsp_last_in_run
);
   import egsd_pkg::*;

   // The zero counter must hold one more than the longest legal prefix.
   localparam int ZeroWidth = $clog2(MAX_PREFIX + 2);

   // Configuration.
   logic [ModeWidth-1:0]   mode_ff;
   logic [LenWidth-1:0]    flen_ff;
   logic [LenWidth-1:0]    flen_eff;

   // Current word.
   logic [ByteWidth-1:0]   byte_ff;
   logic                   eos_ff;
   logic                   bit_val;

   // Code state. In the suffix phase the suffix register holds the code number
   // plus one, seeded with the leading one bit.
   logic                   in_suffix_ff, in_suffix_in;
   logic [ZeroWidth-1:0]   zeros_ff, zeros_in, zeros_inc;
   logic [ZeroWidth-1:0]   bits_left_ff, bits_left_in, bits_left_dec;
   logic [SuffixWidth-1:0] suffix_ff, suffix_in, suffix_shift;
   logic [LenWidth-1:0]    code_bits_ff, code_bits_in, code_bits_inc;

   // Result made by this cycle's step.
   logic                   res_fire;
   res_type                res_new;
   logic [SuffixWidth-1:0] code_num;
   logic [ValueWidth-1:0]  half_mag;
   logic [ValueWidth-1:0]  eg_value;

   // Pending slot and output register.
   res_type                pend_ff;
   logic                   pend_valid_ff;
   logic                   out_free;

   assign bit_val       = byte_ff[ByteWidth-1];
   assign code_bits_inc = code_bits_ff + 1'b1;
   assign zeros_inc     = zeros_ff + 1'b1;
   assign bits_left_dec = (bits_left_ff == '0) ? '0 : bits_left_ff - 1'b1;
   assign suffix_shift  = {suffix_ff[SuffixWidth-2:0], bit_val};

   // Fixed length clamped to its legal range.
   always_comb begin
      if (flen_ff < FLEN_MIN) begin
         flen_eff = FLEN_MIN;
      end else if (flen_ff > FLEN_MAX) begin
         flen_eff = FLEN_MAX;
      end else begin
         flen_eff = flen_ff;
      end
   end

   // Exp-Golomb value from the code number plus one held in suffix_shift.
   // Signed mode maps even (number plus one) to positive, odd to negative.
   assign code_num = suffix_shift - 1'b1;
   assign half_mag = {2'b00, suffix_shift[SuffixWidth-1:1]};
   always_comb begin
      if (mode_ff == MODE_SE) begin
         eg_value = suffix_shift[0] ? (~half_mag + 1'b1) : half_mag;
      end else begin
         eg_value = {1'b0, code_num};
      end
   end

   // One bit of decoding, or the end-of-stream check.
   always_comb begin
      in_suffix_in = in_suffix_ff;
      zeros_in     = zeros_ff;
      bits_left_in = bits_left_ff;
      suffix_in    = suffix_ff;
      code_bits_in = code_bits_ff;
      res_fire     = 1'b0;
      res_new      = '0;
      if (cmd.step) begin
         code_bits_in = code_bits_inc;
         if (mode_ff == MODE_FIXED) begin
            suffix_in = suffix_shift;
            if (code_bits_inc >= flen_eff) begin
               res_fire       = 1'b1;
               res_new.value  = {1'b0, suffix_shift};
               res_new.length = code_bits_inc;
               res_new.status = ST_OK;
            end
         end else if (in_suffix_ff) begin
            suffix_in    = suffix_shift;
            bits_left_in = bits_left_dec;
            if (bits_left_dec == '0) begin
               res_fire       = 1'b1;
               res_new.value  = eg_value;
               res_new.length = code_bits_inc;
               res_new.status = ST_OK;
            end
         end else if (!bit_val) begin
            zeros_in = zeros_inc;
            if (zeros_inc > ZeroWidth'(MAX_PREFIX)) begin
               res_fire       = 1'b1;
               res_new.length = code_bits_inc;
               res_new.status = ST_PREFIX;
            end
         end else if (zeros_ff == '0) begin
            res_fire       = 1'b1;
            res_new.length = code_bits_inc;
            res_new.status = ST_OK;
         end else begin
            in_suffix_in = 1'b1;
            bits_left_in = zeros_ff;
            suffix_in    = SuffixWidth'(1);
         end
      end else if (cmd.trunc) begin
         if (eos_ff && code_bits_ff != '0) begin
            res_fire       = 1'b1;
            res_new.length = code_bits_ff;
            res_new.status = ST_TRUNCATED;
         end
      end
      // A finished code starts over from the prefix.
      if (res_fire) begin
         in_suffix_in = 1'b0;
         zeros_in     = '0;
         bits_left_in = '0;
         suffix_in    = '0;
         code_bits_in = '0;
      end
   end

   // Configuration registers and code state; a write drops any partial code.
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_UE;
         flen_ff      <= FLEN_RESET;
         in_suffix_ff <= 1'b0;
         zeros_ff     <= '0;
         bits_left_ff <= '0;
         suffix_ff    <= '0;
         code_bits_ff <= '0;
      end else if (csr_write_enable) begin
         if (csr_index == REG_MODE) begin
            mode_ff <= csr_write_data[ModeWidth-1:0];
         end else begin
            flen_ff <= csr_write_data;
         end
         in_suffix_ff <= 1'b0;
         zeros_ff     <= '0;
         bits_left_ff <= '0;
         suffix_ff    <= '0;
         code_bits_ff <= '0;
      end else begin
         in_suffix_ff <= in_suffix_in;
         zeros_ff     <= zeros_in;
         bits_left_ff <= bits_left_in;
         suffix_ff    <= suffix_in;
         code_bits_ff <= code_bits_in;
      end
   end

   // Word shift register, most significant bit first.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         byte_ff <= req_stream_byte;
         eos_ff  <= req_end_of_stream;
      end else if (cmd.step) begin
         byte_ff <= {byte_ff[ByteWidth-2:0], 1'b0};
      end
   end

   assign out_free        = !rsp_valid || rsp_ready;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   // A new result waits in the pending slot until the next one shows whether
   // it is the last of its word.
   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
      end else if (res_fire) begin
         pend_valid_ff <= 1'b1;
      end else if (cmd.drain) begin
         pend_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (res_fire) begin
         pend_ff <= res_new;
      end
   end

   // Output register.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if ((res_fire && pend_valid_ff) || cmd.drain) begin
         rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if ((res_fire && pend_valid_ff) || cmd.drain) begin
         rsp_value       <= pend_ff.value;
         rsp_code_length <= pend_ff.length;
         rsp_status      <= pend_ff.status;
         rsp_last_in_run <= cmd.drain;
      end
   end

`ifndef SYNTHESIS
   // The pending result only moves out into a free output register.
   assert property (@(posedge clock) disable iff (reset)
      (res_fire && pend_valid_ff) |-> out_free)
      else $error("pending result pushed over a waiting output");

   // A code never runs past its longest legal length.
   assert property (@(posedge clock) disable iff (reset)
      in_suffix_ff |-> (bits_left_ff != '0 && zeros_ff <= ZeroWidth'(MAX_PREFIX)))
      else $error("suffix phase with no bits left or too long a prefix");

   // A word's final drain leaves nothing behind in the pending slot.
   assert property (@(posedge clock) disable iff (reset)
      cmd.drain |=> !pend_valid_ff)
      else $error("pending slot not empty after drain");
`endif

endmodule

`default_nettype wire

>>> src/exp_golomb_stream_decoder_core.sv
`default_nettype none

// Exp-Golomb stream decoder. Takes the stream one word (byte) at a time, most
// significant bit first, and gives one result word per finished code: ue(v),
// se(v) or u(n) as set by the mode register, with the code's length in bits
// and a status (ok, prefix too long, or truncated at the end of the stream). A
// word is accepted, then takes one step per bit, the end-of-stream check and a
// step to mark the last result of the word; these steps can stall while the
// result channel is busy. Results pass through a one-entry pending slot, so
// each is released once the next result or the end of its word is known, and
// the result register lets a new word enter while the last result still waits
// to be taken. The user must make configuration writes only while no word is
// in flight; the block does not enforce this. Any write drops a partial code.
module exp_golomb_stream_decoder_core #(
   parameter int MAX_PREFIX = 31
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     req_valid,
   output logic                                    req_ready,
   input  wire  [egsd_pkg::ByteWidth-1:0]          req_stream_byte,
   input  wire                                     req_end_of_stream,
   output logic                                    rsp_valid,
   input  wire                                     rsp_ready,
   output logic signed [egsd_pkg::ValueWidth-1:0]  rsp_value,
   output logic [egsd_pkg::LenWidth-1:0]           rsp_code_length,
   output logic [egsd_pkg::StatusWidth-1:0]        rsp_status,
   output logic                                    rsp_last_in_run,
   input  wire                                     csr_write_enable,
   input  wire                                     csr_index,
   input  wire  [egsd_pkg::CsrWidth-1:0]           csr_write_data
);
   import egsd_pkg::*;

   cmd_type  cmd;
   stat_type stat;

   egsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   egsd_datapath #(
      .MAX_PREFIX (MAX_PREFIX)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .stat              (stat),
      .req_stream_byte   (req_stream_byte),
      .req_end_of_stream (req_end_of_stream),
      .csr_write_enable  (csr_write_enable),
      .csr_index         (csr_index),
      .csr_write_data    (csr_write_data),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_value         (rsp_value),
      .rsp_code_length   (rsp_code_length),
      .rsp_status        (rsp_status),
      .rsp_last_in_run   (rsp_last_in_run)
   );

endmodule

`default_nettype wire
